### hdl/ctl_pkg.sv
`timescale 1ns / 1ps
package ctl_pkg;

   localparam int MAX_KEYWORD_LEN = 9;
   localparam int OFFSET_BITS     = 32;
   localparam int NUM_KEYWORDS    = 40;

   localparam logic [15:0] POS_MAX = 16'hFFFF;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   // Token kinds.
   localparam logic [6:0] K_EOF     = 7'd0;
   localparam logic [6:0] K_IDENT   = 7'd1;
   localparam logic [6:0] K_INT     = 7'd2;
   localparam logic [6:0] K_FLOAT   = 7'd3;
   localparam logic [6:0] K_UNKNOWN = 7'd4;
   localparam logic [6:0] K_KW_BASE = 7'd5;
   localparam logic [6:0] K_INC     = 7'd45;
   localparam logic [6:0] K_ADD_EQ  = 7'd46;
   localparam logic [6:0] K_PLUS    = 7'd47;
   localparam logic [6:0] K_DEC     = 7'd48;
   localparam logic [6:0] K_SUB_EQ  = 7'd49;
   localparam logic [6:0] K_ARROW   = 7'd50;
   localparam logic [6:0] K_MINUS   = 7'd51;
   localparam logic [6:0] K_MUL_EQ  = 7'd52;
   localparam logic [6:0] K_STAR    = 7'd53;
   localparam logic [6:0] K_DIV_EQ  = 7'd54;
   localparam logic [6:0] K_SLASH   = 7'd55;
   localparam logic [6:0] K_PERCENT = 7'd56;
   localparam logic [6:0] K_EQ_EQ   = 7'd57;
   localparam logic [6:0] K_ASSIGN  = 7'd58;
   localparam logic [6:0] K_NOT_EQ  = 7'd59;
   localparam logic [6:0] K_NOT     = 7'd60;
   localparam logic [6:0] K_LE      = 7'd61;
   localparam logic [6:0] K_SHL     = 7'd62;
   localparam logic [6:0] K_LT      = 7'd63;
   localparam logic [6:0] K_GE      = 7'd64;
   localparam logic [6:0] K_SHR     = 7'd65;
   localparam logic [6:0] K_GT      = 7'd66;
   localparam logic [6:0] K_AND_AND = 7'd67;
   localparam logic [6:0] K_AMP     = 7'd68;
   localparam logic [6:0] K_OR_OR   = 7'd69;
   localparam logic [6:0] K_PIPE    = 7'd70;
   localparam logic [6:0] K_CARET   = 7'd71;
   localparam logic [6:0] K_TILDE   = 7'd72;
   localparam logic [6:0] K_SCOPE   = 7'd73;
   localparam logic [6:0] K_COLON   = 7'd74;
   localparam logic [6:0] K_QUEST   = 7'd75;
   localparam logic [6:0] K_SEMI    = 7'd76;
   localparam logic [6:0] K_COMMA   = 7'd77;
   localparam logic [6:0] K_HASH    = 7'd78;
   localparam logic [6:0] K_DOT     = 7'd79;
   localparam logic [6:0] K_LPAREN  = 7'd80;
   localparam logic [6:0] K_RPAREN  = 7'd81;
   localparam logic [6:0] K_LBRACE  = 7'd82;
   localparam logic [6:0] K_RBRACE  = 7'd83;
   localparam logic [6:0] K_LBRACK  = 7'd84;
   localparam logic [6:0] K_RBRACK  = 7'd85;
   localparam logic [6:0] K_NONE    = 7'd0;

   // Error codes.
   localparam logic [1:0] E_NONE  = 2'd0;
   localparam logic [1:0] E_QUOTE = 2'd1;
   localparam logic [1:0] E_UNEXP = 2'd2;

   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef logic [8*MAX_KEYWORD_LEN-1:0] word_type;

   // Keywords, right justified and zero padded.
   localparam word_type KW_TEXT [NUM_KEYWORDS] = '{
      "int", "long", "short", "char", "float", "double", "void", "bool",
      "auto", "const", "static", "extern", "class", "struct", "public",
      "private", "protected", "virtual", "override", "template", "typename",
      "using", "namespace", "if", "else", "while", "for", "do", "switch",
      "case", "default", "break", "continue", "return", "new", "delete",
      "this", "true", "false", "nullptr"
   };

   typedef struct packed {
      logic [6:0]             kind;
      logic [15:0]            start_line;
      logic [15:0]            start_column;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [15:0]            token_length;
      logic [1:0]             error_code;
      logic                   last;
   } result_type;

   function automatic logic [15:0] sat16(input logic [15:0] v);
      return (v == POS_MAX) ? v : v + 16'd1;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
      logic [6:0] k;
      k = K_NONE;
      case (p)
         "+": k = (c == "+") ? K_INC : (c == "=") ? K_ADD_EQ : K_NONE;
         "-": k = (c == "-") ? K_DEC : (c == "=") ? K_SUB_EQ :
                  (c == ">") ? K_ARROW : K_NONE;
         "*": k = (c == "=") ? K_MUL_EQ : K_NONE;
         "=": k = (c == "=") ? K_EQ_EQ : K_NONE;
         "!": k = (c == "=") ? K_NOT_EQ : K_NONE;
         "<": k = (c == "=") ? K_LE : (c == "<") ? K_SHL : K_NONE;
         ">": k = (c == "=") ? K_GE : (c == ">") ? K_SHR : K_NONE;
         "&": k = (c == "&") ? K_AND_AND : K_NONE;
         "|": k = (c == "|") ? K_OR_OR : K_NONE;
         ":": k = (c == ":") ? K_SCOPE : K_NONE;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [6:0] single_kind(input logic [7:0] p);
      logic [6:0] k;
      case (p)
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         "*": k = K_STAR;
         "=": k = K_ASSIGN;
         "!": k = K_NOT;
         "<": k = K_LT;
         ">": k = K_GT;
         "&": k = K_AMP;
         "|": k = K_PIPE;
         ":": k = K_COLON;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [6:0] solo_kind(input logic [7:0] c);
      logic [6:0] k;
      case (c)
         "%": k = K_PERCENT;
         "^": k = K_CARET;
         "~": k = K_TILDE;
         "?": k = K_QUEST;
         ";": k = K_SEMI;
         ",": k = K_COMMA;
         "#": k = K_HASH;
         CH_DOT: k = K_DOT;
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         "[": k = K_LBRACK;
         "]": k = K_RBRACK;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

endpackage

### hdl/ctl_req_if.sv
`timescale 1ns / 1ps
interface ctl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_end;

   modport source (output valid, output ch, output is_end, input ready);
   modport sink (input valid, input ch, input is_end, output ready);
endinterface

### hdl/ctl_rsp_if.sv
`timescale 1ns / 1ps
interface ctl_rsp_if
   import ctl_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [6:0]             kind;
   logic [15:0]            start_line;
   logic [15:0]            start_column;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [15:0]            token_length;
   logic [1:0]             error_code;
   logic                   last;

   modport source (output valid, output kind, output start_line, output start_column,
                   output start_offset, output token_length, output error_code,
                   output last, input ready);
   modport sink (input valid, input kind, input start_line, input start_column,
                 input start_offset, input token_length, input error_code,
                 input last, output ready);
endinterface

### hdl/c_like_token_lexer.sv
`timescale 1ns / 1ps
// Streaming lexer for a small C-like language.
// The req_bus channel carries one source byte per item, or an end marker
// (is_end high), which closes the source: any pending token is emitted, then
// an eof token, and the position restarts at line 1, column 1, offset 0.
// The rsp_bus channel carries tokens; an input item causes zero to three of
// them, and the last one of each item has last set.
// An accepted item is held in the input register; the lexer logic then
// updates its state and loads a three-entry result register, from which the
// tokens of the item are offered in order.
// Throughput is one item per cycle while each item yields at most one token
// and the receiver keeps up; an item that yields several tokens holds the result
// register while they are taken in turn, which sets the rate for bursts of tokens.
// When the receiver stalls, the result register and then the input register
// fill, and req_bus.ready drops; nothing is lost. Reset (synchronous, active
// high) empties both registers and returns the lexer to its idle state.
module c_like_token_lexer
   import ctl_pkg::*;
(
   input logic      clock,
   input logic      reset,
   ctl_req_if.sink  req_bus,
   ctl_rsp_if.source rsp_bus
);

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR,
      M_IDENT, M_INT, M_INT_DOT, M_FLOAT, M_PUNCT
   } mode_type;

   // Input register.
   logic       item_v_ff;
   logic [7:0] item_ch_ff;
   logic       item_end_ff;

   // Lexer state.
   mode_type               mode_ff, mode_in;
   logic [7:0]             pend_ff, pend_in;
   logic [7:0]             wbuf_ff [MAX_KEYWORD_LEN];
   logic                   wovf_ff, wovf_in;
   logic [15:0]            tline_ff, tline_in, tcol_ff, tcol_in, tlen_ff, tlen_in;
   logic [OFFSET_BITS-1:0] toff_ff, toff_in;
   logic [15:0]            cline_ff, cline_in, ccol_ff, ccol_in;
   logic [OFFSET_BITS-1:0] coff_ff, coff_in;
   logic [15:0]            dcol_ff, dcol_in;
   logic [OFFSET_BITS-1:0] doff_ff, doff_in;

   logic                   wb_we;
   logic [3:0]             wb_idx;

   // Result register: slot 0 is on the port, later slots shift down.
   result_type slot_ff [3];
   logic [1:0] cnt_ff;

   logic       bundle_free, proc, pop;
   result_type f0, f1, ir;
   logic       f0v, f1v, iv;
   result_type new_slot [3];
   logic [1:0] new_cnt;

   logic [15:0]            nx_line, nx_col;
   logic [OFFSET_BITS-1:0] nx_off;
   logic [7:0]             c;
   logic                   do_idle;
   logic [6:0]             word_kind;
   word_type               word_val;

   assign pop         = rsp_bus.valid && rsp_bus.ready;
   assign bundle_free = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_bus.ready);
   assign proc        = item_v_ff && bundle_free;
   assign req_bus.ready = !item_v_ff || bundle_free;
   assign c = item_ch_ff;

   assign rsp_bus.valid        = cnt_ff != 2'd0;
   assign rsp_bus.kind         = slot_ff[0].kind;
   assign rsp_bus.start_line   = slot_ff[0].start_line;
   assign rsp_bus.start_column = slot_ff[0].start_column;
   assign rsp_bus.start_offset = slot_ff[0].start_offset;
   assign rsp_bus.token_length = slot_ff[0].token_length;
   assign rsp_bus.error_code   = slot_ff[0].error_code;
   assign rsp_bus.last         = slot_ff[0].last;

   // Next position after the current byte.
   always_comb begin
      if (c == CH_LF) begin
         nx_line = sat16(cline_ff);
         nx_col  = 16'd1;
      end else begin
         nx_line = cline_ff;
         nx_col  = sat16(ccol_ff);
      end
      nx_off = (coff_ff == OFFSET_MAX) ? coff_ff : coff_ff + 1'b1;
   end

   // Keyword lookup over the buffered identifier, packed right justified.
   always_comb begin
      word_val  = '0;
      word_kind = K_IDENT;
      for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
         if (tlen_ff > 16'(i)) begin
            word_val = {word_val[8*MAX_KEYWORD_LEN-9:0], wbuf_ff[i]};
         end
      end
      if (!wovf_ff && tlen_ff <= 16'(MAX_KEYWORD_LEN)) begin
         for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (word_val == KW_TEXT[k]) begin
               word_kind = K_KW_BASE + 7'(k);
            end
         end
      end
   end

   // Lexer step for the item in the input register.
   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      wovf_in  = wovf_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      toff_in  = toff_ff;
      tlen_in  = tlen_ff;
      cline_in = nx_line;
      ccol_in  = nx_col;
      coff_in  = nx_off;
      dcol_in  = dcol_ff;
      doff_in  = doff_ff;
      wb_we    = 1'b0;
      wb_idx   = tlen_ff[3:0];
      do_idle  = 1'b0;
      f0v = 1'b0;
      f1v = 1'b0;
      iv  = 1'b0;
      f0 = '{kind: K_INT, start_line: tline_ff, start_column: tcol_ff,
             start_offset: toff_ff, token_length: tlen_ff, error_code: E_NONE,
             last: 1'b0};
      f1 = '{kind: K_DOT, start_line: tline_ff, start_column: dcol_ff,
             start_offset: doff_ff, token_length: 16'd1, error_code: E_NONE,
             last: 1'b0};
      ir = '{kind: K_EOF, start_line: cline_ff, start_column: ccol_ff,
             start_offset: coff_ff, token_length: 16'd0, error_code: E_NONE,
             last: 1'b0};

      if (item_end_ff) begin
         // Flush the pending token, then eof, then start a new source.
         unique case (mode_ff)
            M_SLASH: begin
               f0v = 1'b1;
               f0.kind = K_SLASH;
               f0.token_length = 16'd1;
            end
            M_IDENT: begin
               f0v = 1'b1;
               f0.kind = word_kind;
            end
            M_INT:   f0v = 1'b1;
            M_INT_DOT: begin
               f0v = 1'b1;
               f1v = 1'b1;
            end
            M_FLOAT: begin
               f0v = 1'b1;
               f0.kind = K_FLOAT;
            end
            M_PUNCT: begin
               f0v = 1'b1;
               f0.kind = single_kind(pend_ff);
               f0.token_length = 16'd1;
            end
            default: ;
         endcase
         iv = 1'b1;
         mode_in  = M_IDLE;
         pend_in  = 8'd0;
         wovf_in  = 1'b0;
         tline_in = 16'd1;
         tcol_in  = 16'd1;
         toff_in  = '0;
         tlen_in  = 16'd0;
         cline_in = 16'd1;
         ccol_in  = 16'd1;
         coff_in  = '0;
         dcol_in  = 16'd1;
         doff_in  = '0;
      end else begin
         unique case (mode_ff)
            M_SLASH: begin
               if (c == CH_SLASH) begin
                  mode_in = M_LINE;
               end else if (c == CH_STAR) begin
                  mode_in = M_BLOCK;
               end else if (c == "=") begin
                  f0v = 1'b1;
                  f0.kind = K_DIV_EQ;
                  f0.token_length = 16'd2;
                  mode_in = M_IDLE;
               end else begin
                  f0v = 1'b1;
                  f0.kind = K_SLASH;
                  f0.token_length = 16'd1;
                  do_idle = 1'b1;
               end
            end
            M_LINE: begin
               if (c == CH_LF) mode_in = M_IDLE;
            end
            M_BLOCK: begin
               if (c == CH_STAR) mode_in = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
               if (c == CH_SLASH) mode_in = M_IDLE;
               else if (c != CH_STAR) mode_in = M_BLOCK;
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                  if (tlen_ff < 16'(MAX_KEYWORD_LEN)) wb_we = 1'b1;
                  else wovf_in = 1'b1;
                  tlen_in = sat16(tlen_ff);
               end else begin
                  f0v = 1'b1;
                  f0.kind = word_kind;
                  do_idle = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(c)) begin
                  tlen_in = sat16(tlen_ff);
               end else if (c == CH_DOT) begin
                  dcol_in = ccol_ff;
                  doff_in = coff_ff;
                  mode_in = M_INT_DOT;
               end else begin
                  f0v = 1'b1;
                  do_idle = 1'b1;
               end
            end
            M_INT_DOT: begin
               if (is_digit(c)) begin
                  tlen_in = sat16(sat16(tlen_ff));
                  mode_in = M_FLOAT;
               end else begin
                  f0v = 1'b1;
                  f1v = 1'b1;
                  do_idle = 1'b1;
               end
            end
            M_FLOAT: begin
               if (is_digit(c)) begin
                  tlen_in = sat16(tlen_ff);
               end else begin
                  f0v = 1'b1;
                  f0.kind = K_FLOAT;
                  do_idle = 1'b1;
               end
            end
            M_PUNCT: begin
               if (pair_kind(pend_ff, c) != K_NONE) begin
                  f0v = 1'b1;
                  f0.kind = pair_kind(pend_ff, c);
                  f0.token_length = 16'd2;
                  mode_in = M_IDLE;
               end else begin
                  f0v = 1'b1;
                  f0.kind = single_kind(pend_ff);
                  f0.token_length = 16'd1;
                  do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         // The byte starts afresh from the idle state.
         if (do_idle) begin
            mode_in = M_IDLE;
            if (!is_space(c)) begin
               if (c == CH_SLASH || is_alpha(c) || c == CH_UNDER || is_digit(c) ||
                   single_kind(c) != K_NONE || solo_kind(c) != K_NONE) begin
                  tline_in = cline_ff;
                  tcol_in  = ccol_ff;
                  toff_in  = coff_ff;
                  tlen_in  = 16'd1;
               end
               if (c == CH_SLASH) begin
                  mode_in = M_SLASH;
               end else if (is_alpha(c) || c == CH_UNDER) begin
                  wb_we   = 1'b1;
                  wb_idx  = 4'd0;
                  wovf_in = 1'b0;
                  mode_in = M_IDENT;
               end else if (is_digit(c)) begin
                  mode_in = M_INT;
               end else if (single_kind(c) != K_NONE) begin
                  pend_in = c;
                  mode_in = M_PUNCT;
               end else if (solo_kind(c) != K_NONE) begin
                  iv = 1'b1;
                  ir.kind = solo_kind(c);
                  ir.token_length = 16'd1;
               end else begin
                  // Stray byte: reported just after itself.
                  iv = 1'b1;
                  ir.kind = K_UNKNOWN;
                  ir.start_line = nx_line;
                  ir.start_column = nx_col;
                  ir.start_offset = nx_off;
                  ir.error_code = (c == "\"" || c == "'") ? E_QUOTE : E_UNEXP;
               end
            end
         end
      end
   end

   // Pack the tokens in order and mark the final one.
   always_comb begin
      new_slot[0] = f0v ? f0 : ir;
      new_slot[1] = f1v ? f1 : ir;
      new_slot[2] = ir;
      new_cnt = 2'(f0v) + 2'(f1v) + 2'(iv);
      for (int i = 0; i < 3; i++) begin
         new_slot[i].last = (2'(i) == new_cnt - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         mode_ff   <= M_IDLE;
         pend_ff   <= 8'd0;
         wovf_ff   <= 1'b0;
         tline_ff  <= 16'd1;
         tcol_ff   <= 16'd1;
         toff_ff   <= '0;
         tlen_ff   <= 16'd0;
         cline_ff  <= 16'd1;
         ccol_ff   <= 16'd1;
         coff_ff   <= '0;
         dcol_ff   <= 16'd1;
         doff_ff   <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            item_v_ff   <= 1'b1;
            item_ch_ff  <= req_bus.ch;
            item_end_ff <= req_bus.is_end;
         end else if (proc) begin
            item_v_ff <= 1'b0;
         end

         if (proc) begin
            slot_ff  <= new_slot;
            cnt_ff   <= new_cnt;
            mode_ff  <= mode_in;
            pend_ff  <= pend_in;
            wovf_ff  <= wovf_in;
            tline_ff <= tline_in;
            tcol_ff  <= tcol_in;
            toff_ff  <= toff_in;
            tlen_ff  <= tlen_in;
            cline_ff <= cline_in;
            ccol_ff  <= ccol_in;
            coff_ff  <= coff_in;
            dcol_ff  <= dcol_in;
            doff_ff  <= doff_in;
            if (wb_we && !item_end_ff) wbuf_ff[wb_idx] <= c;
         end else if (pop) begin
            slot_ff[0] <= slot_ff[1];
            slot_ff[1] <= slot_ff[2];
            cnt_ff     <= cnt_ff - 2'd1;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3 || !item_v_ff || !bundle_free || proc)
      else $error("result count inconsistent");
   a_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == K_UNKNOWN |->
      rsp_bus.error_code != E_NONE && rsp_bus.token_length == 16'd0)
      else $error("unknown token without error code");
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error_code != E_NONE |-> rsp_bus.kind == K_UNKNOWN)
      else $error("error code on a regular token");
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind == K_EOF |-> rsp_bus.last)
      else $error("eof is not the final token of its item");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      item_v_ff && !bundle_free |=> item_v_ff)
      else $error("input item dropped while blocked");
`endif

endmodule
